// ----- rtl/core/hpe_pkg.sv -----
// Package for the HPACK Huffman encoder: payload types and code table.
`timescale 1ns / 1ps
package hpe_pkg;

   localparam int MaxBytes = 5;

   typedef struct packed {
      logic [7:0] symbol;
      logic       final_symbol;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        last_byte;
      logic [15:0] bytes_so_far;
   } rsp_payload_type;

   function automatic logic [29:0] code_bits(input logic [7:0] s);
      logic [29:0] t [256];
      t = '{
 30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,30'hfffffe7,
 30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,30'h3ffffffd,30'hfffffeb,30'hfffffec,
 30'hfffffed,30'hfffffee,30'hfffffef,30'hffffff0,30'hffffff1,30'hffffff2,30'h3ffffffe,30'hffffff3,
 30'hffffff4,30'hffffff5,30'hffffff6,30'hffffff7,30'hffffff8,30'hffffff9,30'hffffffa,30'hffffffb,
 30'h14,30'h3f8,30'h3f9,30'hffa,30'h1ff9,30'h15,30'hf8,30'h7fa,
 30'h3fa,30'h3fb,30'hf9,30'h7fb,30'hfa,30'h16,30'h17,30'h18,
 30'h0,30'h1,30'h2,30'h19,30'h1a,30'h1b,30'h1c,30'h1d,
 30'h1e,30'h1f,30'h5c,30'hfb,30'h7ffc,30'h20,30'hffb,30'h3fc,
 30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,30'h61,30'h62,
 30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6a,
 30'h6b,30'h6c,30'h6d,30'h6e,30'h6f,30'h70,30'h71,30'h72,
 30'hfc,30'h73,30'hfd,30'h1ffb,30'h7fff0,30'h1ffc,30'h3ffc,30'h22,
 30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,
 30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2a,30'h7,
 30'h2b,30'h76,30'h2c,30'h8,30'h9,30'h2d,30'h77,30'h78,
 30'h79,30'h7a,30'h7b,30'h7ffe,30'h7fc,30'h3ffd,30'h1ffd,30'hffffffc,
 30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,30'h3fffd3,30'h3fffd4,30'h3fffd5,30'h7fffd9,
 30'h3fffd6,30'h7fffda,30'h7fffdb,30'h7fffdc,30'h7fffdd,30'h7fffde,30'hffffeb,30'h7fffdf,
 30'hffffec,30'hffffed,30'h3fffd7,30'h7fffe0,30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,
 30'h7fffe4,30'h1fffdc,30'h3fffd8,30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,
 30'h3fffda,30'h1fffdd,30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,30'h1fffde,
 30'h7fffea,30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,30'h7fffeb,30'h7fffec,
 30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,30'h3fffe1,30'h7fffee,30'h7fffef,
 30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,30'h7ffff0,30'h3fffe5,30'h3fffe6,30'h7ffff1,
 30'h3ffffe0,30'h3ffffe1,30'hfffeb,30'h7fff1,30'h3fffe7,30'h7ffff2,30'h3fffe8,30'h1ffffec,
 30'h3ffffe2,30'h3ffffe3,30'h3ffffe4,30'h7ffffde,30'h7ffffdf,30'h3ffffe5,30'hfffff1,30'h1ffffed,
 30'h7fff2,30'h1fffe3,30'h3ffffe6,30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,30'h7ffffe2,30'hfffff2,
 30'h1fffe4,30'h1fffe5,30'h3ffffe8,30'h3ffffe9,30'hffffffd,30'h7ffffe3,30'h7ffffe4,30'h7ffffe5,
 30'hfffec,30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,30'h1fffe8,30'h7ffff3,
 30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,30'hfffff5,30'h3ffffea,30'h7ffff4,
 30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,30'h7ffffe7,30'h7ffffe8,30'h7ffffe9,30'h7ffffea,
 30'h7ffffeb,30'hffffffe,30'h7ffffec,30'h7ffffed,30'h7ffffee,30'h7ffffef,30'h7fffff0,30'h3ffffee};
      return t[s];
   endfunction

   function automatic logic [4:0] code_len(input logic [7:0] s);
      logic [4:0] t [256];
      t = '{
 5'd13,5'd23,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd24,5'd30,5'd28,5'd28,5'd30,5'd28,5'd28,
 5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd30,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,5'd28,
 5'd6,5'd10,5'd10,5'd12,5'd13,5'd6,5'd8,5'd11,5'd10,5'd10,5'd8,5'd11,5'd8,5'd6,5'd6,5'd6,
 5'd5,5'd5,5'd5,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd6,5'd7,5'd8,5'd15,5'd6,5'd12,5'd10,
 5'd13,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,
 5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd7,5'd8,5'd7,5'd8,5'd13,5'd19,5'd13,5'd14,5'd6,
 5'd15,5'd5,5'd6,5'd5,5'd6,5'd5,5'd6,5'd6,5'd6,5'd5,5'd7,5'd7,5'd6,5'd6,5'd6,5'd5,
 5'd6,5'd7,5'd6,5'd5,5'd5,5'd6,5'd7,5'd7,5'd7,5'd7,5'd7,5'd15,5'd11,5'd14,5'd13,5'd28,
 5'd20,5'd22,5'd20,5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd23,5'd23,5'd23,5'd23,5'd23,5'd24,5'd23,
 5'd24,5'd24,5'd22,5'd23,5'd24,5'd23,5'd23,5'd23,5'd23,5'd21,5'd22,5'd23,5'd22,5'd23,5'd23,5'd24,
 5'd22,5'd21,5'd20,5'd22,5'd22,5'd23,5'd23,5'd21,5'd23,5'd22,5'd22,5'd24,5'd21,5'd22,5'd23,5'd23,
 5'd21,5'd21,5'd22,5'd21,5'd23,5'd22,5'd23,5'd23,5'd20,5'd22,5'd22,5'd22,5'd23,5'd22,5'd22,5'd23,
 5'd26,5'd26,5'd20,5'd19,5'd22,5'd23,5'd22,5'd25,5'd26,5'd26,5'd26,5'd27,5'd27,5'd26,5'd24,5'd25,
 5'd19,5'd21,5'd26,5'd27,5'd27,5'd26,5'd27,5'd24,5'd21,5'd21,5'd26,5'd26,5'd28,5'd27,5'd27,5'd27,
 5'd20,5'd24,5'd20,5'd21,5'd22,5'd21,5'd21,5'd23,5'd22,5'd22,5'd25,5'd25,5'd24,5'd24,5'd26,5'd23,
 5'd26,5'd27,5'd26,5'd26,5'd27,5'd27,5'd27,5'd27,5'd27,5'd28,5'd27,5'd27,5'd27,5'd27,5'd27,5'd26};
      return t[s];
   endfunction

endpackage

// ----- rtl/core/hpack_huffman_encoder_core.sv -----
// HPACK static Huffman encoder: octets in, encoded bytes out.
//
//   channel | dir | payload            | handshake
//   req     | in  | symbol, final flag | req_valid / req_stall
//   rsp     | out | byte, last, count  | rsp_valid / rsp_stall
//
// A request is registered with its code, then packed into a byte buffer of up to
// five bytes once the buffer is free. The buffer drains one byte per cycle while
// rsp_stall is low; a request yields up to 4 bytes, or 5 on a final request with
// a pad byte.
// One request waits in the request register while the buffer drains; req_stall
// rises once that register is full and the buffer is not emptying. Synchronous
// reset clears all valid bits, the partial byte and the byte count. rsp_stall
// holds the current byte.
`timescale 1ns / 1ps
module hpack_huffman_encoder_core
   import hpe_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   // stage 1: request register with looked-up code
   logic        s1_valid_ff, s1_valid_in;
   logic [29:0] s1_bits_ff;
   logic [4:0]  s1_len_ff;
   logic        s1_fin_ff;

   // stage 2: byte buffer, left aligned
   logic [39:0] buf_ff, buf_in;
   logic [2:0]  buf_cnt_ff, buf_cnt_in;   // bytes left
   logic        buf_fin_ff, buf_fin_in;

   // partial byte between requests
   logic [6:0]  part_ff, part_in;
   logic [2:0]  part_n_ff, part_n_in;
   logic [15:0] count_ff, count_in;

   logic        s1_take, buf_pop, buf_load, buf_free;
   logic [36:0] joined;
   logic [5:0]  total;
   logic [2:0]  full_bytes, rem;
   logic [39:0] packed_word;
   logic [36:0] rem_mask;

   assign buf_pop  = (buf_cnt_ff != 3'd0) && !rsp_stall;
   assign buf_free = (buf_cnt_ff == 3'd0) || (buf_pop && buf_cnt_ff == 3'd1);
   assign buf_load = s1_valid_ff && buf_free;
   assign req_stall = s1_valid_ff && !buf_free;
   assign s1_take  = req_valid && !req_stall;

   always_comb begin
      total      = 6'(part_n_ff) + 6'(s1_len_ff);
      joined     = (37'(part_ff) << s1_len_ff) | 37'(s1_bits_ff);
      full_bytes = total[5:3];
      rem        = total[2:0];
      // left align all held bits in 40 bits
      packed_word = 40'(joined) << (6'd40 - total);
      rem_mask    = (37'd1 << rem) - 37'd1;
      if (s1_fin_ff && rem != 3'd0)
         packed_word = packed_word | (40'hFF_FFFF_FFFF >> total);
   end

   always_comb begin
      s1_valid_in = s1_take ? 1'b1 : (buf_load ? 1'b0 : s1_valid_ff);
      buf_in      = buf_ff;
      buf_cnt_in  = buf_cnt_ff;
      buf_fin_in  = buf_fin_ff;
      part_in     = part_ff;
      part_n_in   = part_n_ff;
      if (buf_pop) begin
         buf_in     = buf_ff << 8;
         buf_cnt_in = buf_cnt_ff - 3'd1;
      end
      if (buf_load) begin
         buf_in     = packed_word;
         buf_fin_in = s1_fin_ff;
         if (s1_fin_ff) begin
            buf_cnt_in = full_bytes + ((rem != 3'd0) ? 3'd1 : 3'd0);
            part_in    = '0;
            part_n_in  = '0;
         end else begin
            buf_cnt_in = full_bytes;
            part_in    = 7'(joined & rem_mask);
            part_n_in  = rem;
         end
      end
      count_in = count_ff;
      if (buf_pop) begin
         if (buf_fin_ff && buf_cnt_ff == 3'd1)
            count_in = '0;
         else if (count_ff != 16'hFFFF)
            count_in = count_ff + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         buf_cnt_ff  <= '0;
         buf_fin_ff  <= 1'b0;
         part_ff     <= '0;
         part_n_ff   <= '0;
         count_ff    <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         buf_cnt_ff  <= buf_cnt_in;
         buf_fin_ff  <= buf_fin_in;
         part_ff     <= part_in;
         part_n_ff   <= part_n_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
      if (s1_take) begin
         s1_bits_ff <= code_bits(req_payload.symbol);
         s1_len_ff  <= code_len(req_payload.symbol);
         s1_fin_ff  <= req_payload.final_symbol;
      end
   end

   assign rsp_valid                = buf_cnt_ff != 3'd0;
   assign rsp_payload.out_byte     = buf_ff[39:32];
   assign rsp_payload.last_byte    = buf_fin_ff && buf_cnt_ff == 3'd1;
   assign rsp_payload.bytes_so_far = (count_ff == 16'hFFFF) ? count_ff : count_ff + 16'd1;

endmodule

// ----- dv/hpack_huffman_encoder_core_tb.sv -----
// Testbench for the HPACK Huffman encoder core: predicts encoded bytes and checks them.
`timescale 1ns / 1ps
module hpack_huffman_encoder_core_tb;
   import hpe_pkg::*;

   class encoded_byte_scoreboard;
      logic [29:0]     code_table [256];
      logic [4:0]      len_table [256];
      logic [39:0]     acc;
      int unsigned     held_bits;
      int unsigned     out_count;
      rsp_payload_type pending_bytes [$];
      int              mismatch_count;

      function new();
         logic [29:0] c [256];
         logic [4:0]  l [256];
         c = '{
 30'h1ff8,30'h7fffd8,30'hfffffe2,30'hfffffe3,30'hfffffe4,30'hfffffe5,30'hfffffe6,30'hfffffe7,
 30'hfffffe8,30'hffffea,30'h3ffffffc,30'hfffffe9,30'hfffffea,30'h3ffffffd,30'hfffffeb,
 30'hfffffec,30'hfffffed,30'hfffffee,30'hfffffef,30'hffffff0,30'hffffff1,30'hffffff2,
 30'h3ffffffe,30'hffffff3,30'hffffff4,30'hffffff5,30'hffffff6,30'hffffff7,30'hffffff8,
 30'hffffff9,30'hffffffa,30'hffffffb,
 30'h14,30'h3f8,30'h3f9,30'hffa,30'h1ff9,30'h15,30'hf8,30'h7fa,
 30'h3fa,30'h3fb,30'hf9,30'h7fb,30'hfa,30'h16,30'h17,30'h18,
 30'h0,30'h1,30'h2,30'h19,30'h1a,30'h1b,30'h1c,30'h1d,
 30'h1e,30'h1f,30'h5c,30'hfb,30'h7ffc,30'h20,30'hffb,30'h3fc,
 30'h1ffa,30'h21,30'h5d,30'h5e,30'h5f,30'h60,30'h61,30'h62,
 30'h63,30'h64,30'h65,30'h66,30'h67,30'h68,30'h69,30'h6a,
 30'h6b,30'h6c,30'h6d,30'h6e,30'h6f,30'h70,30'h71,30'h72,
 30'hfc,30'h73,30'hfd,30'h1ffb,30'h7fff0,30'h1ffc,30'h3ffc,30'h22,
 30'h7ffd,30'h3,30'h23,30'h4,30'h24,30'h5,30'h25,30'h26,
 30'h27,30'h6,30'h74,30'h75,30'h28,30'h29,30'h2a,30'h7,
 30'h2b,30'h76,30'h2c,30'h8,30'h9,30'h2d,30'h77,30'h78,
 30'h79,30'h7a,30'h7b,30'h7ffe,30'h7fc,30'h3ffd,30'h1ffd,30'hffffffc,
 30'hfffe6,30'h3fffd2,30'hfffe7,30'hfffe8,30'h3fffd3,30'h3fffd4,30'h3fffd5,30'h7fffd9,
 30'h3fffd6,30'h7fffda,30'h7fffdb,30'h7fffdc,30'h7fffdd,30'h7fffde,30'hffffeb,30'h7fffdf,
 30'hffffec,30'hffffed,30'h3fffd7,30'h7fffe0,30'hffffee,30'h7fffe1,30'h7fffe2,30'h7fffe3,
 30'h7fffe4,30'h1fffdc,30'h3fffd8,30'h7fffe5,30'h3fffd9,30'h7fffe6,30'h7fffe7,30'hffffef,
 30'h3fffda,30'h1fffdd,30'hfffe9,30'h3fffdb,30'h3fffdc,30'h7fffe8,30'h7fffe9,30'h1fffde,
 30'h7fffea,30'h3fffdd,30'h3fffde,30'hfffff0,30'h1fffdf,30'h3fffdf,30'h7fffeb,30'h7fffec,
 30'h1fffe0,30'h1fffe1,30'h3fffe0,30'h1fffe2,30'h7fffed,30'h3fffe1,30'h7fffee,30'h7fffef,
 30'hfffea,30'h3fffe2,30'h3fffe3,30'h3fffe4,30'h7ffff0,30'h3fffe5,30'h3fffe6,30'h7ffff1,
 30'h3ffffe0,30'h3ffffe1,30'hfffeb,30'h7fff1,30'h3fffe7,30'h7ffff2,30'h3fffe8,30'h1ffffec,
 30'h3ffffe2,30'h3ffffe3,30'h3ffffe4,30'h7ffffde,30'h7ffffdf,30'h3ffffe5,30'hfffff1,
 30'h1ffffed,30'h7fff2,30'h1fffe3,30'h3ffffe6,30'h7ffffe0,30'h7ffffe1,30'h3ffffe7,
 30'h7ffffe2,30'hfffff2,30'h1fffe4,30'h1fffe5,30'h3ffffe8,30'h3ffffe9,30'hffffffd,
 30'h7ffffe3,30'h7ffffe4,30'h7ffffe5,
 30'hfffec,30'hfffff3,30'hfffed,30'h1fffe6,30'h3fffe9,30'h1fffe7,30'h1fffe8,30'h7ffff3,
 30'h3fffea,30'h3fffeb,30'h1ffffee,30'h1ffffef,30'hfffff4,30'hfffff5,30'h3ffffea,30'h7ffff4,
 30'h3ffffeb,30'h7ffffe6,30'h3ffffec,30'h3ffffed,30'h7ffffe7,30'h7ffffe8,30'h7ffffe9,
 30'h7ffffea,30'h7ffffeb,30'hffffffe,30'h7ffffec,30'h7ffffed,30'h7ffffee,30'h7ffffef,
 30'h7fffff0,30'h3ffffee};
         l = '{
 13,23,28,28,28,28,28,28,28,24,30,28,28,30,28,28,
 28,28,28,28,28,28,30,28,28,28,28,28,28,28,28,28,
 6,10,10,12,13,6,8,11,10,10,8,11,8,6,6,6,
 5,5,5,6,6,6,6,6,6,6,7,8,15,6,12,10,
 13,6,7,7,7,7,7,7,7,7,7,7,7,7,7,7,
 7,7,7,7,7,7,7,7,8,7,8,13,19,13,14,6,
 15,5,6,5,6,5,6,6,6,5,7,7,6,6,6,5,
 6,7,6,5,5,6,7,7,7,7,7,15,11,14,13,28,
 20,22,20,20,22,22,22,23,22,23,23,23,23,23,24,23,
 24,24,22,23,24,23,23,23,23,21,22,23,22,23,23,24,
 22,21,20,22,22,23,23,21,23,22,22,24,21,22,23,23,
 21,21,22,21,23,22,23,23,20,22,22,22,23,22,22,23,
 26,26,20,19,22,23,22,25,26,26,26,27,27,26,24,25,
 19,21,26,27,27,26,27,24,21,21,26,26,28,27,27,27,
 20,24,20,21,22,21,21,23,22,22,25,25,24,24,26,23,
 26,27,26,26,27,27,27,27,27,28,27,27,27,27,27,26};
         code_table = c;
         len_table = l;
         acc = '0;
         held_bits = 0;
         out_count = 0;
         mismatch_count = 0;
      endfunction

      function void push_byte(logic [7:0] b, logic last);
         rsp_payload_type r;
         if (out_count < 65535) out_count++;
         r.out_byte = b;
         r.last_byte = last;
         r.bytes_so_far = out_count[15:0];
         pending_bytes.push_back(r);
      endfunction

      function void note_request(req_payload_type rq);
         int unsigned len;
         int unsigned fill;
         len = len_table[rq.symbol];
         acc = (acc << len) | 40'(code_table[rq.symbol]);
         held_bits += len;
         while (held_bits >= 8) begin
            held_bits -= 8;
            push_byte(8'(acc >> held_bits), rq.final_symbol && held_bits == 0);
         end
         acc &= (40'd1 << held_bits) - 40'd1;
         if (rq.final_symbol) begin
            if (held_bits > 0) begin
               fill = 8 - held_bits;
               push_byte(8'((acc << fill) | ((40'd1 << fill) - 1)), 1'b1);
            end
            acc = '0;
            held_bits = 0;
            out_count = 0;
         end
      endfunction

      function void check_byte(rsp_payload_type got);
         rsp_payload_type want;
         if (pending_bytes.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected byte %h last %b count %0d",
                        got.out_byte, got.last_byte, got.bytes_so_far);
            return;
         end
         want = pending_bytes.pop_front();
         if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("mismatch: exp byte %h last %b count %0d, got %h %b %0d",
                        want.out_byte, want.last_byte, want.bytes_so_far,
                        got.out_byte, got.last_byte, got.bytes_so_far);
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_payload;

   encoded_byte_scoreboard sb;
   bit  calm_phase = 1'b0;
   bit  stimulus_done = 1'b0;

   hpack_huffman_encoder_core u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // receiver side: random stall, check on accept
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_byte(rsp_payload);
      rsp_stall <= !calm_phase && ($urandom_range(99) < 25);
   end

   // one request; idles first at random, then holds until accepted.
   // valid stays up after the accept; the next idle or drain drops it.
   task automatic send_request(logic [7:0] s, logic f);
      while (!calm_phase && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= '{symbol: s, final_symbol: f};
      do @(posedge clock); while (req_stall);
      sb.note_request('{symbol: s, final_symbol: f});
   endtask

   task automatic drain_expected();
      req_valid <= 1'b0;
      while (sb.pending_bytes.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int n;
      int len;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: short/long codes, byte boundary, one-octet strings
      send_request(8'd48, 1'b1);
      send_request(8'd255, 1'b1);
      send_request(8'd10, 1'b0);
      send_request(8'd13, 1'b0);
      send_request(8'd22, 1'b1);
      send_request(8'd38, 1'b0);   // 8-bit code, ends on boundary
      send_request(8'd42, 1'b1);
      send_request(8'd0, 1'b0);
      send_request(8'd97, 1'b0);
      send_request(8'd128, 1'b0);
      send_request(8'd127, 1'b1);
      send_request(8'd49, 1'b0);
      send_request(8'd50, 1'b0);
      send_request(8'd170, 1'b0);
      send_request(8'd85, 1'b1);
      drain_expected();
      // random strings; a calm stretch in the middle
      n = 0;
      while (n < 150) begin
         calm_phase = (n >= 60 && n < 90);
         len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) begin
            send_request(8'($urandom_range(255)), i == len - 1);
            n++;
         end
         if (n > 100 && n < 110) drain_expected();
      end
      calm_phase = 1'b0;
      drain_expected();
      if (sb.mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end
endmodule
